>>> sv/cossim_pkg.sv
// Package for the cosine similarity stream core.
// Widths, sequencer state codes and square root request/response types.
package cossim_pkg;

	localparam int ELEM_W   = 16;
	localparam int ACC_W    = 48;
	localparam int MUL_W    = 25;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int ROOT_W   = ACC_W / 2;
	localparam int REM_W    = ROOT_W + 3;
	localparam int Q_FRAC   = 15;
	localparam int DIVD_W   = ACC_W + Q_FRAC;
	localparam int QUO_W    = ELEM_W + 1;
	localparam int SCNT_W   = $clog2(ROOT_W);
	localparam int DCNT_W   = $clog2(DIVD_W);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_MAC   = 8'b0000_0010,
		ST_CHECK = 8'b0000_0100,
		ST_SQA   = 8'b0000_1000,
		ST_SQB   = 8'b0001_0000,
		ST_MULR  = 8'b0010_0000,
		ST_DIV   = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic               start;
		logic [ACC_W-1:0]   rad;
	} sqrt_req_t;

	typedef struct packed {
		logic               done;
		logic [ROOT_W-1:0]  root;
	} sqrt_rsp_t;

endpackage

>>> sv/cossim_in_if.sv
// Input channel: one element pair and a last flag per item.
// Depends on cossim_pkg.
interface cossim_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [cossim_pkg::ELEM_W-1:0] elem_a;
	logic signed [cossim_pkg::ELEM_W-1:0] elem_b;
	logic                                last;

	modport source (output valid, output elem_a, output elem_b, output last, input ready);
	modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

>>> sv/cossim_out_if.sv
// Output channel: similarity result and zero norm flag per item.
// Depends on cossim_pkg.
interface cossim_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [cossim_pkg::ELEM_W-1:0] similarity;
	logic                                zero_norm;

	modport source (output valid, output similarity, output zero_norm, input ready);
	modport sink   (input valid, input similarity, input zero_norm, output ready);
endinterface

>>> sv/cossim_isqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on cossim_pkg.
module cossim_isqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cossim_pkg::sqrt_req_t  req,
	output cossim_pkg::sqrt_rsp_t  rsp
);
	logic [cossim_pkg::ACC_W-1:0]  rad_q;
	logic [cossim_pkg::REM_W-1:0]  rem_q;
	logic [cossim_pkg::ROOT_W-1:0] root_q;
	logic [cossim_pkg::SCNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [cossim_pkg::REM_W-1:0]  rem_sh;
	logic [cossim_pkg::REM_W-1:0]  trial;

	assign rem_sh = {rem_q[cossim_pkg::REM_W-3:0], rad_q[cossim_pkg::ACC_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == cossim_pkg::SCNT_W'(cossim_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[cossim_pkg::ACC_W-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[cossim_pkg::ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[cossim_pkg::ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q;
endmodule

>>> sv/cosine_similarity_stream_core.sv
// Cosine similarity stream core. Item with last=0: accept and MAC, then ready again.
// Item with last=1: accept, MAC, check, square root of each norm, multiply of the roots,
// divide and result; check goes straight to result when a norm is zero. The square
// roots share one square root unit, and the divider is bit serial.
// One item in flight; the result register lets the next item in while a result waits.
// arst_n clears the sequencer, accumulators and output valid.
module cosine_similarity_stream_core (
	input  logic          clk,
	input  logic          arst_n,
	cossim_in_if.sink     in_ch,
	cossim_out_if.source  out_ch
);
	localparam int AW = cossim_pkg::ACC_W;

	cossim_pkg::state_t    state_q;
	logic [1:0]            ph_q;
	logic signed [cossim_pkg::ELEM_W-1:0] a_q, b_q;
	logic                  last_q;
	logic [AW-1:0]         dot_q, na_q, nb_q;
	logic signed [cossim_pkg::PROD_W-1:0] prod_q;
	logic signed [cossim_pkg::MUL_W-1:0]  op_x, op_y;
	logic [cossim_pkg::ROOT_W-1:0] root_a_q, root_b_q;
	logic                  neg_q, zf_q, ovf_q;
	logic [AW-1:0]         den_q, rem_q;
	logic [cossim_pkg::DIVD_W-1:0] divd_q;
	logic [cossim_pkg::QUO_W-1:0]  quo_q;
	logic [cossim_pkg::DCNT_W-1:0] cnt_q;
	logic [AW:0]           rem_sh;
	logic                  nz;
	logic [cossim_pkg::ELEM_W-1:0] sim_c;
	logic                  out_valid_q, out_zf_q;
	logic [cossim_pkg::ELEM_W-1:0] out_sim_q;
	cossim_pkg::sqrt_req_t sq_req;
	cossim_pkg::sqrt_rsp_t sq_rsp;

	cossim_isqrt u_isqrt (.clk(clk), .arst_n(arst_n), .req(sq_req), .rsp(sq_rsp));

	assign in_ch.ready = (state_q == cossim_pkg::ST_IDLE);
	assign nz = (na_q != '0) && (nb_q != '0);
	assign sq_req.start = ((state_q == cossim_pkg::ST_CHECK) && nz) ||
	                      ((state_q == cossim_pkg::ST_SQA) && sq_rsp.done);
	assign sq_req.rad = (state_q == cossim_pkg::ST_CHECK) ? na_q : nb_q;
	assign rem_sh = {rem_q, divd_q[cossim_pkg::DIVD_W-1]};

	always_comb begin
		op_x = cossim_pkg::MUL_W'(a_q);
		op_y = cossim_pkg::MUL_W'(b_q);
		if (state_q == cossim_pkg::ST_MULR) begin
			op_x = {1'b0, root_a_q};
			op_y = {1'b0, root_b_q};
		end else if (ph_q == 2'd1) begin
			op_y = cossim_pkg::MUL_W'(a_q);
		end else if (ph_q == 2'd2) begin
			op_x = cossim_pkg::MUL_W'(b_q);
		end
	end

	always_comb begin
		if (zf_q) begin
			sim_c = '0;
		end else if (neg_q) begin
			if (ovf_q || quo_q > cossim_pkg::QUO_W'(32768)) sim_c = 16'h8000;
			else sim_c = cossim_pkg::ELEM_W'(~quo_q + 1'b1);
		end else begin
			if (ovf_q || quo_q > cossim_pkg::QUO_W'(32767)) sim_c = 16'h7FFF;
			else sim_c = quo_q[cossim_pkg::ELEM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cossim_pkg::ST_IDLE;
			ph_q        <= '0;
			dot_q       <= '0;
			na_q        <= '0;
			nb_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) out_valid_q <= 1'b0;
			case (state_q)
				cossim_pkg::ST_IDLE: begin
					ph_q <= '0;
					if (in_ch.valid) state_q <= cossim_pkg::ST_MAC;
				end
				cossim_pkg::ST_MAC: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd1) dot_q <= dot_q + prod_q[AW-1:0];
					if (ph_q == 2'd2) na_q <= na_q + prod_q[AW-1:0];
					if (ph_q == 2'd3) begin
						nb_q    <= nb_q + prod_q[AW-1:0];
						state_q <= last_q ? cossim_pkg::ST_CHECK : cossim_pkg::ST_IDLE;
					end
				end
				cossim_pkg::ST_CHECK: begin
					ph_q    <= '0;
					state_q <= nz ? cossim_pkg::ST_SQA : cossim_pkg::ST_DONE;
				end
				cossim_pkg::ST_SQA: begin
					if (sq_rsp.done) state_q <= cossim_pkg::ST_SQB;
				end
				cossim_pkg::ST_SQB: begin
					if (sq_rsp.done) state_q <= cossim_pkg::ST_MULR;
				end
				cossim_pkg::ST_MULR: begin
					ph_q <= ph_q + 1'b1;
					if (ph_q == 2'd1) state_q <= cossim_pkg::ST_DIV;
				end
				cossim_pkg::ST_DIV: begin
					if (cnt_q == cossim_pkg::DCNT_W'(cossim_pkg::DIVD_W - 1))
						state_q <= cossim_pkg::ST_DONE;
				end
				cossim_pkg::ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						dot_q       <= '0;
						na_q        <= '0;
						nb_q        <= '0;
						state_q     <= cossim_pkg::ST_IDLE;
					end
				end
				default: state_q <= cossim_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= op_x * op_y;
		if (in_ch.valid && in_ch.ready) begin
			a_q    <= in_ch.elem_a;
			b_q    <= in_ch.elem_b;
			last_q <= in_ch.last;
		end
		if (state_q == cossim_pkg::ST_CHECK) begin
			zf_q  <= !nz;
			neg_q <= dot_q[AW-1];
			divd_q <= {(dot_q[AW-1] ? (~dot_q + 1'b1) : dot_q),
			           {cossim_pkg::Q_FRAC{1'b0}}};
		end
		if (state_q == cossim_pkg::ST_SQA && sq_rsp.done) root_a_q <= sq_rsp.root;
		if (state_q == cossim_pkg::ST_SQB && sq_rsp.done) root_b_q <= sq_rsp.root;
		if (state_q == cossim_pkg::ST_MULR && ph_q == 2'd1) begin
			den_q <= prod_q[AW-1:0];
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
			cnt_q <= '0;
		end
		if (state_q == cossim_pkg::ST_DIV) begin
			cnt_q  <= cnt_q + 1'b1;
			divd_q <= {divd_q[cossim_pkg::DIVD_W-2:0], 1'b0};
			ovf_q  <= ovf_q | quo_q[cossim_pkg::QUO_W-1];
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= AW'(rem_sh - {1'b0, den_q});
				quo_q <= {quo_q[cossim_pkg::QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[AW-1:0];
				quo_q <= {quo_q[cossim_pkg::QUO_W-2:0], 1'b0};
			end
		end
		if (state_q == cossim_pkg::ST_DONE && (!out_valid_q || out_ch.ready)) begin
			out_sim_q <= sim_c;
			out_zf_q  <= zf_q;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.similarity = out_sim_q;
	assign out_ch.zero_norm  = out_zf_q;

`ifndef NO_ASSERTIONS
	a_accept_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> (state_q == cossim_pkg::ST_MAC))
		else $error("accepted item did not start accumulation");
	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cossim_pkg::ST_DIV) |-> (den_q != '0))
		else $error("divide with zero denominator");
	a_zero_sim: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.zero_norm) |-> (out_ch.similarity == '0))
		else $error("zero norm result with nonzero similarity");
`endif
endmodule

>>> bench/cosine_similarity_stream_core_test.sv
// Testbench for cosine_similarity_stream_core: directed table, then random vectors.
// Depends on cossim_pkg, cossim_in_if, cossim_out_if and the core RTL.
// Results are checked field by field against a predictor of the fixed-point math.
`timescale 1ns / 100ps

module cosine_similarity_stream_core_test;

	typedef struct {
		logic signed [cossim_pkg::ELEM_W-1:0] a;
		logic signed [cossim_pkg::ELEM_W-1:0] b;
		logic                                 last;
		logic                                 has_exp;
		logic signed [cossim_pkg::ELEM_W-1:0] exp_sim;
		logic                                 exp_zero;
	} stim_row_t;

	typedef struct {
		logic signed [cossim_pkg::ELEM_W-1:0] sim;
		logic                                 zero;
	} sim_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors = 0;
	bit   stim_done = 1'b0;

	cossim_in_if  in_ch();
	cossim_out_if out_ch();

	cosine_similarity_stream_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("TB_ERROR");
		$finish;
	end

	logic [cossim_pkg::ACC_W-1:0] dot_sum, norm_a_sum, norm_b_sum;
	sim_result_t      pending_sims[$];
	stim_row_t        rows[$];

	task automatic put_row(input stim_row_t r);
		rows.insert(rows.size(), r);
	endtask

	function automatic logic [cossim_pkg::ROOT_W-1:0] floor_sqrt(
		logic [cossim_pkg::ACC_W-1:0] n);
		logic [cossim_pkg::ROOT_W-1:0] r;
		r = '0;
		for (int i = cossim_pkg::ROOT_W - 1; i >= 0; i--) begin
			logic [cossim_pkg::ROOT_W-1:0] t;
			t = r | (cossim_pkg::ROOT_W'(1) << i);
			if ({48'b0, t} * {48'b0, t} <= {48'b0, n})
				r = t;
		end
		return r;
	endfunction

	task automatic accumulate(input stim_row_t it);
		logic signed [31:0] pa, pb, pd;
		logic [cossim_pkg::ACC_W-1:0] mag, den;
		logic [63:0]        q;
		logic               neg;
		sim_result_t        res;
		pa = it.a * it.a;
		pb = it.b * it.b;
		pd = it.a * it.b;
		dot_sum = dot_sum + cossim_pkg::ACC_W'(signed'(pd));
		norm_a_sum = norm_a_sum + cossim_pkg::ACC_W'(signed'(pa));
		norm_b_sum = norm_b_sum + cossim_pkg::ACC_W'(signed'(pb));
		if (!it.last)
			return;
		if (norm_a_sum == 0 || norm_b_sum == 0) begin
			res.sim = '0;
			res.zero = 1'b1;
		end else begin
			neg = dot_sum[cossim_pkg::ACC_W-1];
			mag = neg ? -dot_sum : dot_sum;
			den = cossim_pkg::ACC_W'(floor_sqrt(norm_a_sum)) *
			      cossim_pkg::ACC_W'(floor_sqrt(norm_b_sum));
			q = ({16'b0, mag} << cossim_pkg::Q_FRAC) / {16'b0, den};
			if (neg)
				res.sim = (q > 32768) ? 16'sh8000 : cossim_pkg::ELEM_W'(-q);
			else
				res.sim = (q > 32767) ? 16'sh7fff : cossim_pkg::ELEM_W'(q);
			res.zero = 1'b0;
		end
		if (it.has_exp && res.sim !== it.exp_sim) begin
			$error("similarity expected %0d actual %0d", it.exp_sim, res.sim);
			errors++;
		end
		if (it.has_exp && res.zero !== it.exp_zero) begin
			$error("zero_norm expected %0d actual %0d", it.exp_zero, res.zero);
			errors++;
		end
		pending_sims.insert(pending_sims.size(), res);
		dot_sum = '0;
		norm_a_sum = '0;
		norm_b_sum = '0;
	endtask

	function automatic stim_row_t mk(int a, int b, bit last, bit has = 0, int s = 0, bit z = 0);
		stim_row_t r;
		r.a = cossim_pkg::ELEM_W'(a); r.b = cossim_pkg::ELEM_W'(b); r.last = last;
		r.has_exp = has; r.exp_sim = cossim_pkg::ELEM_W'(s); r.exp_zero = z;
		return r;
	endfunction

	function automatic logic signed [cossim_pkg::ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return cossim_pkg::ELEM_W'($urandom_range(0, 15)) - 16'sd8;
			default: return cossim_pkg::ELEM_W'($urandom);
		endcase
	endfunction

	// Stimulus build: directed rows then random vectors of mostly short length.
	initial begin
		int n, len;
		logic signed [cossim_pkg::ELEM_W-1:0] a;
		put_row(mk(0, 0, 1, 1, 0, 1));
		put_row(mk(32767, 32767, 1, 1, 32767, 0));
		put_row(mk(-32768, -32768, 1, 1, 32767, 0));
		put_row(mk(-32768, 32767, 1, 1, -32768, 0));
		put_row(mk(32767, -32768, 1, 1, -32768, 0));
		put_row(mk(5, 0, 1, 1, 0, 1));
		put_row(mk(0, -7, 1, 1, 0, 1));
		put_row(mk(1, 1, 1, 1, 32767, 0));
		put_row(mk(-1, 1, 1, 1, -32768, 0));
		put_row(mk(100, 0, 0));
		put_row(mk(0, 100, 1, 1, 0, 0));
		put_row(mk(3, 4, 0));
		put_row(mk(4, -3, 1));
		put_row(mk(-32768, 12345, 0));
		put_row(mk(-32768, -4321, 0));
		put_row(mk(21845, 10922, 1));
		put_row(mk(1000, 999, 0));
		put_row(mk(-5461, 0, 0));
		put_row(mk(0, 0, 1));
		n = 0;
		while (n < 1300) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 200) : $urandom_range(1, 8);
			if (len > 1300 - n)
				len = 1300 - n;
			for (int i = 0; i < len; i++) begin
				a = rand_elem();
				if ($urandom_range(0, 3) == 0)
					put_row(mk(a, ($urandom_range(0, 1) ? a : -a), i == len - 1));
				else
					put_row(mk(a, rand_elem(), i == len - 1));
				n++;
			end
		end
	end

	initial begin
		stim_row_t it;
		int burst;
		int gap;
		dot_sum = '0; norm_a_sum = '0; norm_b_sum = '0;
		in_ch.valid <= 1'b0;
		in_ch.elem_a <= '0;
		in_ch.elem_b <= '0;
		in_ch.last <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst = 0;
		while (rows.size() > 0) begin
			it = rows.pop_front();
			if (burst == 0) begin
				gap = $urandom_range(0, 6);
				if (gap > 0) begin
					in_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 30);
			end
			in_ch.valid <= 1'b1;
			in_ch.elem_a <= it.a;
			in_ch.elem_b <= it.b;
			in_ch.last <= it.last;
			@(posedge clk);
			while (!in_ch.ready) @(posedge clk);
			accumulate(it);
			burst--;
		end
		in_ch.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver: periodic stall pattern plus one long hold-off.
	initial begin
		int k;
		out_ch.ready <= 1'b0;
		wait (arst_n);
		k = 0;
		forever begin
			@(posedge clk);
			k++;
			if (k == 3000) begin
				out_ch.ready <= 1'b0;
				repeat (1500) @(posedge clk);
			end
			out_ch.ready <= (k % 7 < 4) || ((k / 500) % 3 == 0) || ($urandom_range(0, 3) == 0);
		end
	end

	always @(posedge clk) begin
		sim_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_sims.size() == 0) begin
				$error("unexpected result: similarity %0d", out_ch.similarity);
				errors++;
			end else begin
				want = pending_sims.pop_front();
				if (out_ch.similarity !== want.sim) begin
					$error("similarity expected %0d actual %0d", want.sim, out_ch.similarity);
					errors++;
				end
				if (out_ch.zero_norm !== want.zero) begin
					$error("zero_norm expected %0d actual %0d", want.zero, out_ch.zero_norm);
					errors++;
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		while (pending_sims.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0 && pending_sims.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
sv/cossim_pkg.sv
sv/cossim_in_if.sv
sv/cossim_out_if.sv
sv/cossim_isqrt.sv
sv/cosine_similarity_stream_core.sv
bench/cosine_similarity_stream_core_test.sv
